>>> src/assert_macros.svh
// Assertion macros shared by the partitioned multi-stack RTL.
// Needs signals named clock and reset in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PMS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define PMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);

`endif

>>> src/pms_pkg.sv
// Package for the partitioned multi-stack: widths, register indexes, status codes
// and the memory control word. No dependencies.
`timescale 1ns / 1ps

package pms_pkg;

   localparam int NUM_STACKS_DEF = 4;
   localparam int MEM_DEPTH_DEF  = 256;
   localparam int DATA_WIDTH_DEF = 32;

   // Only four stacks can be addressed and sized through the ports.
   localparam int MAX_IDS   = 4;
   localparam int ID_W      = 2;
   localparam int ACT_W     = 3;
   localparam int FILL_W    = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 9;
   localparam int PORT_W    = 32;
   // Wide enough for any base plus fill and for the largest memory depth.
   localparam int EXT_W     = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE0  = 3'd1;

   typedef enum logic {
      OP_PUSH,
      OP_POP
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_OVERFLOW,
      STATUS_UNDERFLOW,
      STATUS_INACTIVE
   } status_type;

   typedef struct packed {
      logic en;
      logic we;
   } mem_ctrl_type;

   function automatic int num_ids(input int stacks);
      return (stacks < MAX_IDS) ? stacks : MAX_IDS;
   endfunction

endpackage

>>> src/pms_csr.sv
// Configuration registers of the partitioned multi-stack: active stack count
// and region sizes. Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_csr #(
   parameter int NUM_IDS = pms_pkg::MAX_IDS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       wr_en,
   input  logic [pms_pkg::CSR_IDX_W-1:0]              wr_index,
   input  logic [pms_pkg::CSR_DAT_W-1:0]              wr_data,
   output logic [pms_pkg::ACT_W-1:0]                  active_stacks,
   output logic [NUM_IDS-1:0][pms_pkg::FILL_W-1:0]    region_sizes
);
   import pms_pkg::*;

   logic [ACT_W-1:0]                 active_ff;
   logic [NUM_IDS-1:0][FILL_W-1:0]   sizes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACT_W'(1);
         sizes_ff  <= '0;
      end else if (wr_en) begin
         if (wr_index == CSR_ACTIVE) begin
            active_ff <= wr_data[ACT_W-1:0];
         end
         // Size registers for stacks that do not exist are dropped.
         for (int k = 0; k < NUM_IDS; k++) begin
            if (wr_index == CSR_SIZE0 + CSR_IDX_W'(k)) begin
               sizes_ff[k] <= wr_data[FILL_W-1:0];
            end
         end
      end
   end

   assign active_stacks = active_ff;
   assign region_sizes  = sizes_ff;

endmodule

>>> src/pms_mem.sv
// Shared data memory of the partitioned multi-stack: one port, read before
// write, registered read data. Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_mem #(
   parameter int DEPTH = pms_pkg::MEM_DEPTH_DEF,
   parameter int WIDTH = pms_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  pms_pkg::mem_ctrl_type             ctrl,
   input  logic [$clog2(DEPTH)-1:0]          addr,
   input  logic [WIDTH-1:0]                  wdata,
   output logic [WIDTH-1:0]                  rdata
);
   import pms_pkg::*;

   logic [WIDTH-1:0] data_mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A pop reads the old word and clears the entry in the same access.
   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         rdata_ff <= data_mem[addr];
         if (ctrl.we) begin
            data_mem[addr] <= wdata;
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/pms_ctrl.sv
// Request control of the partitioned multi-stack: region base and capacity,
// fill counters, memory commands and the result register. Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_ctrl #(
   parameter int NUM_IDS    = pms_pkg::MAX_IDS,
   parameter int MEM_DEPTH  = pms_pkg::MEM_DEPTH_DEF,
   parameter int DATA_WIDTH = pms_pkg::DATA_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       accept,
   input  logic                                       req_operation,
   input  logic [pms_pkg::ID_W-1:0]                   req_stack_id,
   input  logic signed [pms_pkg::PORT_W-1:0]          req_push_value,
   input  logic [pms_pkg::ACT_W-1:0]                  active_stacks,
   input  logic [NUM_IDS-1:0][pms_pkg::FILL_W-1:0]    region_sizes,
   output pms_pkg::mem_ctrl_type                      mem_ctrl,
   output logic [$clog2(MEM_DEPTH)-1:0]               mem_addr,
   output logic [DATA_WIDTH-1:0]                      mem_wdata,
   input  logic [DATA_WIDTH-1:0]                      mem_rdata,
   output logic                                       rsp_valid,
   output logic [1:0]                                 rsp_status,
   output logic signed [pms_pkg::PORT_W-1:0]          rsp_pop_value,
   output logic [pms_pkg::FILL_W-1:0]                 rsp_fill_level
);
   import pms_pkg::*;

   localparam int AW = $clog2(MEM_DEPTH);
   localparam logic [EXT_W-1:0] DEPTH_X = EXT_W'(MEM_DEPTH);
   localparam logic [ACT_W-1:0] IDS_X   = ACT_W'(NUM_IDS);

   logic [NUM_IDS-1:0][FILL_W-1:0] fill_ff;
   logic                           rsp_valid_ff;
   status_type                     rsp_status_ff;
   logic [FILL_W-1:0]              rsp_fill_ff;
   logic                           pop_ok_ff;

   logic                   active_id;
   logic [EXT_W-1:0]       base;
   logic [EXT_W-1:0]       room;
   logic [EXT_W-1:0]       cap;
   logic [EXT_W-1:0]       size_x;
   logic [FILL_W-1:0]      fill_cur;
   logic [EXT_W-1:0]       fill_x;
   logic [EXT_W-1:0]       addr_x;
   logic [FILL_W-1:0]      fill_in;
   logic                   fill_we;
   status_type             status_in;
   logic                   pop_ok_in;

   always_comb begin
      active_id = (ACT_W'(req_stack_id) < active_stacks) && (ACT_W'(req_stack_id) < IDS_X);
      base      = '0;
      size_x    = '0;
      fill_cur  = '0;
      for (int k = 0; k < NUM_IDS; k++) begin
         if (k < int'(req_stack_id)) begin
            base = base + EXT_W'(region_sizes[k]);
         end
         if (ID_W'(k) == req_stack_id) begin
            size_x   = EXT_W'(region_sizes[k]);
            fill_cur = fill_ff[k];
         end
      end
      fill_x = EXT_W'(fill_cur);

      // A region that starts at or past the end of memory has no room.
      room = (base >= DEPTH_X) ? '0 : DEPTH_X - base;
      cap  = (size_x < room) ? size_x : room;

      status_in = STATUS_OK;
      fill_in   = '0;
      fill_we   = 1'b0;
      pop_ok_in = 1'b0;
      addr_x    = base + fill_x;
      mem_ctrl  = '0;
      mem_wdata = DATA_WIDTH'($unsigned(req_push_value));

      if (!active_id) begin
         status_in = STATUS_INACTIVE;
      end else if (op_type'(req_operation) == OP_PUSH) begin
         if (fill_x >= cap) begin
            status_in = STATUS_OVERFLOW;
            fill_in   = fill_cur;
         end else begin
            fill_in     = fill_cur + FILL_W'(1);
            fill_we     = 1'b1;
            mem_ctrl.en = 1'b1;
            mem_ctrl.we = 1'b1;
         end
      end else begin
         if (fill_cur == '0) begin
            status_in = STATUS_UNDERFLOW;
         end else begin
            addr_x  = base + fill_x - EXT_W'(1);
            fill_in = fill_cur - FILL_W'(1);
            fill_we = 1'b1;
            mem_wdata = '0;
            // After a shrink the top may lie past the memory; then nothing is read.
            if (addr_x < DEPTH_X) begin
               pop_ok_in   = 1'b1;
               mem_ctrl.en = 1'b1;
               mem_ctrl.we = 1'b1;
            end
         end
      end

      if (!accept) begin
         mem_ctrl = '0;
      end
   end

   assign mem_addr = addr_x[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept && fill_we) begin
            for (int k = 0; k < NUM_IDS; k++) begin
               if (ID_W'(k) == req_stack_id) begin
                  fill_ff[k] <= fill_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_fill_ff   <= fill_in;
         pop_ok_ff     <= pop_ok_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_pop_value  = pop_ok_ff ? PORT_W'(mem_rdata) : '0;

endmodule

>>> src/partitioned_multi_stack_top.sv
// Channel   | Ports                                   | Handshake
// request   | req_operation, req_stack_id, req_push_value | start & !busy
// response  | rsp_status, rsp_pop_value, rsp_fill_level   | rsp_valid strobe, one cycle
// csr write | csr_index, csr_wdata                     | csr_valid & csr_ready
//
// A request is taken in any cycle with start high and busy low; up to one per cycle.
// Its word appears on the rsp_ ports in the next cycle, set by the single
// read-before-write access to the data memory and its registered read data.
// Reset is synchronous; busy stays high and csr_ready low until the cycle after it.
// The data memory needs no clearing pass. The receiver cannot stall the response.
// Top level of the partitioned multi-stack. Depends on pms_pkg, pms_csr, pms_mem,
// pms_ctrl and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module partitioned_multi_stack_top #(
   parameter int NUM_STACKS = pms_pkg::NUM_STACKS_DEF,
   parameter int MEM_DEPTH  = pms_pkg::MEM_DEPTH_DEF,
   parameter int DATA_WIDTH = pms_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [pms_pkg::ID_W-1:0]            req_stack_id,
   input  logic signed [pms_pkg::PORT_W-1:0]   req_push_value,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic signed [pms_pkg::PORT_W-1:0]   rsp_pop_value,
   output logic [pms_pkg::FILL_W-1:0]          rsp_fill_level,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pms_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pms_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import pms_pkg::*;

   localparam int NUM_IDS = num_ids(NUM_STACKS);
   localparam int AW      = $clog2(MEM_DEPTH);

   logic                           init_ff;
   logic                           accept;
   logic [ACT_W-1:0]               active_stacks;
   logic [NUM_IDS-1:0][FILL_W-1:0] region_sizes;
   mem_ctrl_type                   mem_ctrl;
   logic [AW-1:0]                  mem_addr;
   logic [DATA_WIDTH-1:0]          mem_wdata;
   logic [DATA_WIDTH-1:0]          mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b1;
      end else begin
         init_ff <= 1'b0;
      end
   end

   assign busy      = init_ff;
   assign csr_ready = !init_ff;
   assign accept    = start && !init_ff;

   pms_csr #(
      .NUM_IDS (NUM_IDS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .wr_en         (csr_valid && csr_ready),
      .wr_index      (csr_index),
      .wr_data       (csr_wdata),
      .active_stacks (active_stacks),
      .region_sizes  (region_sizes)
   );

   pms_mem #(
      .DEPTH (MEM_DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock (clock),
      .ctrl  (mem_ctrl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   pms_ctrl #(
      .NUM_IDS    (NUM_IDS),
      .MEM_DEPTH  (MEM_DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_operation  (req_operation),
      .req_stack_id   (req_stack_id),
      .req_push_value (req_push_value),
      .active_stacks  (active_stacks),
      .region_sizes   (region_sizes),
      .mem_ctrl       (mem_ctrl),
      .mem_addr       (mem_addr),
      .mem_wdata      (mem_wdata),
      .mem_rdata      (mem_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_fill_level (rsp_fill_level)
   );

   // Every accepted request gives exactly one response word, in the next cycle.
   `PMS_ASSERT_NEXT(a_rsp_follows, start && !busy, rsp_valid, "response word missing")
   `PMS_ASSERT_NEXT(a_rsp_only_after, !(start && !busy), !rsp_valid, "response word invented")
   // Only a successful pop may return data.
   `PMS_ASSERT(a_pop_zero, rsp_valid && rsp_status != STATUS_OK |-> rsp_pop_value == '0, "pop value on failure")
   `PMS_ASSERT(a_inactive_fill, rsp_valid && rsp_status == STATUS_INACTIVE |-> rsp_fill_level == '0, "fill reported for inactive stack")

endmodule

>>> tb/partitioned_multi_stack_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for partitioned_multi_stack_top: push and pop requests on stacks that
// share one memory, under changing region sizes, with every response word checked in order.
// Depends on pms_pkg and the partitioned_multi_stack_top RTL.

module partitioned_multi_stack_top_test;
   import pms_pkg::*;

   localparam int DEPTH    = MEM_DEPTH_DEF;
   localparam int SIZE_MAX = (1 << CSR_DAT_W) - 1;
   // Copy 0 of the stack state runs ahead as items are queued, copy 1 follows the block.
   localparam int PLANNED  = 0;
   localparam int TRACKED  = 1;
   // An index past the register list; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      op_type            op;
      logic [ID_W-1:0]   id;
      logic [PORT_W-1:0] value;
   } stack_req_type;

   typedef struct packed {
      status_type        status;
      logic [PORT_W-1:0] pop_value;
      logic [FILL_W-1:0] fill;
   } stack_rsp_type;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     start          = 1'b0;
   logic                     busy;
   logic                     req_operation  = 1'b0;
   logic [ID_W-1:0]          req_stack_id   = '0;
   logic signed [PORT_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic signed [PORT_W-1:0] rsp_pop_value;
   logic [FILL_W-1:0]        rsp_fill_level;
   logic                     csr_valid      = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index      = '0;
   logic [CSR_DAT_W-1:0]     csr_wdata      = '0;

   logic [ACT_W-1:0]  active_r  [2];
   logic [FILL_W-1:0] size_r    [2][MAX_IDS];
   logic [FILL_W-1:0] level_r   [2][MAX_IDS];
   logic [PORT_W-1:0] store_r   [2][DEPTH];
   bit                written_r [2][DEPTH];

   stack_req_type req_backlog[$];
   stack_rsp_type rsp_due[$];
   stack_req_type next_req;
   stack_req_type taken_req;
   stack_rsp_type want;
   int            sender_idle_pct = 37;
   logic          req_taken       = 1'b0;
   int            fault_count     = 0;

   partitioned_multi_stack_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_stack_id   (req_stack_id),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_fill_level (rsp_fill_level),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int live_ids(input int c);
      return (int'(active_r[c]) < NUM_STACKS_DEF) ? int'(active_r[c]) : NUM_STACKS_DEF;
   endfunction

   function automatic int region_base(input int c, input int id);
      int sum;
      sum = 0;
      for (int k = 0; k < id; k++) sum += int'(size_r[c][k]);
      return sum;
   endfunction

   // Works out the response word for one request and updates that copy of the stacks.
   function automatic stack_rsp_type stack_access(input int c, input stack_req_type r);
      stack_rsp_type o;
      int            id, base, room, cap, lvl, addr;
      id          = int'(r.id);
      o.status    = STATUS_OK;
      o.pop_value = '0;
      o.fill      = '0;
      if (id >= live_ids(c)) begin
         o.status = STATUS_INACTIVE;
         return o;
      end
      base = region_base(c, id);
      room = (base >= DEPTH) ? 0 : DEPTH - base;
      cap  = (int'(size_r[c][id]) < room) ? int'(size_r[c][id]) : room;
      lvl  = int'(level_r[c][id]);
      if (r.op == OP_PUSH) begin
         if (lvl >= cap) begin
            o.status = STATUS_OVERFLOW;
         end else begin
            store_r[c][base + lvl]   = r.value;
            written_r[c][base + lvl] = 1'b1;
            lvl++;
         end
      end else if (lvl == 0) begin
         o.status = STATUS_UNDERFLOW;
      end else begin
         // A shrunk region can leave the top beyond the memory: nothing is read there.
         addr = base + lvl - 1;
         if (addr < DEPTH) begin
            o.pop_value      = store_r[c][addr];
            store_r[c][addr] = '0;
         end
         lvl--;
      end
      level_r[c][id] = FILL_W'(lvl);
      o.fill         = FILL_W'(lvl);
      return o;
   endfunction

   function automatic void apply_register(input int c, input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DAT_W-1:0] data);
      int slot;
      slot = int'(idx) - int'(CSR_SIZE0);
      if (idx == CSR_ACTIVE) begin
         active_r[c] = data[ACT_W-1:0];
      end else if (slot >= 0 && slot < MAX_IDS && slot < NUM_STACKS_DEF) begin
         size_r[c][slot] = data;
      end
   endfunction

   // True where a pop would read an entry that has never been written since reset.
   function automatic bit pop_hits_unwritten(input int id);
      int addr;
      if (id >= live_ids(PLANNED) || level_r[PLANNED][id] == '0) return 1'b0;
      addr = region_base(PLANNED, id) + int'(level_r[PLANNED][id]) - 1;
      return addr < DEPTH && !written_r[PLANNED][addr];
   endfunction

   task automatic queue_req(input op_type op, input int id, input logic [PORT_W-1:0] value);
      stack_req_type r;
      r.op    = op;
      r.id    = ID_W'(id);
      r.value = value;
      void'(stack_access(PLANNED, r));
      req_backlog.push_back(r);
   endtask

   task automatic settle();
      do @(posedge clock); while (req_backlog.size() != 0 || start || rsp_due.size() != 0);
   endtask

   task automatic write_csr(input int idx, input int data);
      apply_register(PLANNED, CSR_IDX_W'(idx), CSR_DAT_W'(data));
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= CSR_DAT_W'(data);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int random_size();
      case ($urandom_range(9))
         0: return 0;
         1: return DEPTH;
         2: return $urandom_range(DEPTH + 1, SIZE_MAX);
         3, 4, 5: return $urandom_range(1, 4);
         default: return $urandom_range(5, 40);
      endcase
   endfunction

   task automatic random_setup();
      int pick;
      pick = $urandom_range(11);
      if (pick == 0) write_csr(CSR_ACTIVE, 0);
      else if (pick == 1) write_csr(CSR_ACTIVE, $urandom_range(5, 7));
      else write_csr(CSR_ACTIVE, $urandom_range(1, MAX_IDS));
      for (int k = 0; k < MAX_IDS; k++) write_csr(int'(CSR_SIZE0) + k, random_size());
   endtask

   // Runs of mostly pushes or mostly pops, so that stacks reach both full and empty.
   task automatic random_phase(input int n_items);
      int     run_left, id, live;
      bit     filling;
      op_type op;
      run_left = 0;
      filling  = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(4, 24);
            filling  = $urandom_range(99) < 55;
         end
         run_left--;
         live = live_ids(PLANNED);
         if (live == 0 || $urandom_range(9) == 0) id = $urandom_range(ID_W'(-1));
         else id = $urandom_range(live - 1);
         op = (($urandom_range(9) < 8) == filling) ? OP_PUSH : OP_POP;
         if (op == OP_POP && pop_hits_unwritten(id)) op = OP_PUSH;
         queue_req(op, id, $urandom());
      end
   endtask

   task automatic drain_stacks();
      for (int id = 0; id < live_ids(PLANNED); id++) begin
         while (level_r[PLANNED][id] != '0 && !pop_hits_unwritten(id))
            queue_req(OP_POP, id, $urandom());
      end
   endtask

   task automatic check_field(input string name, input logic [PORT_W-1:0] expected_val,
                              input logic [PORT_W-1:0] actual_val);
      if (actual_val !== expected_val) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name,
                     expected_val, actual_val);
      end
   endtask

   // Request driver: a word is held until the block takes it.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_req = req_backlog.pop_front();
            start          <= 1'b1;
            req_operation  <= next_req.op;
            req_stack_id   <= next_req.id;
            req_push_value <= next_req.value;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks each response word and predicts the one for each accepted request.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_valid) begin
            if (rsp_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: response word with none outstanding, status %0d",
                           $realtime, rsp_status);
            end else begin
               want = rsp_due.pop_front();
               check_field("status", PORT_W'(want.status), PORT_W'(rsp_status));
               check_field("pop_value", want.pop_value, rsp_pop_value);
               check_field("fill_level", PORT_W'(want.fill), PORT_W'(rsp_fill_level));
            end
         end
         if (csr_valid && csr_ready) apply_register(TRACKED, csr_index, csr_wdata);
         if (start && !busy) begin
            taken_req.op    = op_type'(req_operation);
            taken_req.id    = req_stack_id;
            taken_req.value = req_push_value;
            rsp_due.push_back(stack_access(TRACKED, taken_req));
         end
      end
   end

   initial begin
      for (int c = 0; c < 2; c++) begin
         active_r[c] = ACT_W'(1);
         for (int k = 0; k < MAX_IDS; k++) begin
            size_r[c][k]  = '0;
            level_r[c][k] = '0;
         end
         for (int a = 0; a < DEPTH; a++) begin
            store_r[c][a]   = '0;
            written_r[c][a] = 1'b0;
         end
      end
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Out of reset there is one stack with no room at all.
      queue_req(OP_PUSH, 0, 32'h0000_0001);
      queue_req(OP_POP, 0, 32'h0000_0000);
      queue_req(OP_PUSH, 1, 32'h1234_5678);
      queue_req(OP_POP, 3, 32'h0000_0000);
      settle();
      write_csr(CSR_ACTIVE, 0);
      queue_req(OP_POP, 0, 32'hFFFF_FFFF);
      settle();

      // More active stacks than exist; the last region is cut off at the end of memory.
      write_csr(CSR_ACTIVE, 7);
      write_csr(int'(CSR_SIZE0), 2);
      write_csr(int'(CSR_SIZE0) + 1, 1);
      write_csr(CSR_SPARE, 5);
      write_csr(int'(CSR_SIZE0) + 2, 0);
      write_csr(int'(CSR_SIZE0) + 3, SIZE_MAX);
      queue_req(OP_PUSH, 0, 32'h7FFF_FFFF);
      queue_req(OP_PUSH, 0, 32'h8000_0000);
      queue_req(OP_PUSH, 0, 32'hFFFF_FFFF);
      queue_req(OP_PUSH, 2, 32'h0F0F_0F0F);
      queue_req(OP_PUSH, 1, 32'hAAAA_AAAA);
      queue_req(OP_PUSH, 3, 32'h5555_5555);
      queue_req(OP_POP, 1, 32'hFFFF_FFFF);
      queue_req(OP_POP, 0, 32'h0000_0000);
      queue_req(OP_POP, 0, 32'h0000_0000);
      queue_req(OP_POP, 0, 32'h0000_0000);
      queue_req(OP_POP, 3, 32'h0000_0000);
      settle();

      // Fill stack 1 at the top of memory, then move its base so that the fill is past
      // its room and the upper entries lie beyond the memory.
      write_csr(CSR_ACTIVE, 2);
      write_csr(int'(CSR_SIZE0), DEPTH - 3);
      write_csr(int'(CSR_SIZE0) + 1, 3);
      queue_req(OP_PUSH, 1, 32'h0000_0000);
      queue_req(OP_PUSH, 1, 32'hFFFF_FFFF);
      queue_req(OP_PUSH, 1, 32'hC001_D00D);
      settle();
      write_csr(int'(CSR_SIZE0), DEPTH - 1);
      queue_req(OP_PUSH, 1, 32'h1111_1111);
      queue_req(OP_POP, 1, 32'h0000_0000);
      queue_req(OP_POP, 1, 32'h0000_0000);
      queue_req(OP_POP, 1, 32'h0000_0000);
      queue_req(OP_POP, 1, 32'h0000_0000);
      settle();

      for (int p = 0; p < 9; p++) begin
         sender_idle_pct = (p < 3) ? 37 : (p < 6) ? 62 : 0;
         random_setup();
         random_phase(66);
         settle();
         if ($urandom_range(1) == 1) begin
            drain_stacks();
            settle();
         end
      end

      repeat (5) @(posedge clock);
      if (fault_count == 0) begin
         $display("partitioned_multi_stack_top_test: done, clean");
      end else begin
         $display("partitioned_multi_stack_top_test: done, errors");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("partitioned_multi_stack_top_test: done, errors");
      $finish;
   end

endmodule
